/* design/otp_pkg.sv */
// ----------------------------------------------------------------------------
// otp_pkg
// Shared types and constants for the OID path token parser: token, request
// and error codes, buffer sizing, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package otp_pkg;

  // OID buffer capacity and derived widths
  localparam int unsigned MAX_OID_LEN = 32;
  localparam int unsigned CNT_W       = $clog2(MAX_OID_LEN + 1);
  localparam int unsigned IDX_W       = (MAX_OID_LEN > 1) ? $clog2(MAX_OID_LEN) : 1;

  // Input token codes; anything above TK_OTHER is treated as other
  typedef enum logic [3:0] {
    TK_END    = 4'd0,
    TK_LPAREN = 4'd1,
    TK_RPAREN = 4'd2,
    TK_COMMA  = 4'd3,
    TK_NUMBER = 4'd4,
    TK_DOT    = 4'd5,
    TK_STAR   = 4'd6,
    TK_PLUS   = 4'd7,
    TK_OTHER  = 4'd8
  } tok_e;

  // Request type carried by the status result
  typedef enum logic [1:0] {
    RQ_GET  = 2'd0,
    RQ_NEXT = 2'd1,
    RQ_WALK = 2'd2
  } rq_e;

  // Dense error codes
  typedef enum logic [3:0] {
    ERR_OK     = 4'd0,
    ERR_EOF    = 4'd1,
    ERR_LPAREN = 4'd2,
    ERR_RPAREN = 4'd3,
    ERR_COMMA  = 4'd4,
    ERR_NUMBER = 4'd5,
    ERR_DOT    = 4'd6,
    ERR_STAR   = 4'd7,
    ERR_PLUS   = 4'd8,
    ERR_TOKEN  = 4'd9
  } err_e;

  // Result kind
  typedef enum logic {
    KIND_SUB    = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic store_num;  // write number into buffer if room
    logic clr_count;  // empty the buffer
    logic idx_clr;    // restart emission index, prefetch entry 0
    logic load_sub;   // load output with prefetched sub-identifier
    logic load_stat;  // load output with status
    logic sub_last;   // final sub-identifier ends this request's results
    rq_e  stat_rq;
    err_e stat_err;
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic count_zero; // buffer is empty
    logic sub_final;  // current emission index is the last entry
    logic out_free;   // output register can take a result this cycle
  } dp_sts_t;

endpackage

/* design/oid_path_token_parser_top.sv */
// ----------------------------------------------------------------------------
// oid_path_token_parser_top
// OID path token parser: collects dotted numbers into an OID buffer and
// emits buffered OIDs and a closing status result per path.
// ----------------------------------------------------------------------------
// Tokens that only advance the parse (numbers, dots, left parens, illegal or
// ignored tokens) are taken one per cycle while no results drain. A terminator
// token is taken and then blocks the input while its results drain: each
// buffered sub-identifier, then the status result on an end token, with any
// output-side stall on top. The draining is done by the result sequencer,
// which reads the OID buffer through its single registered read port into
// the one-deep output register. Up to 32 sub-identifiers are kept per OID;
// further numbers are accepted and dropped. After an illegal token everything
// up to the end token is swallowed, the end token then gives a status result
// with the recorded error, and the parser restarts.
module oid_path_token_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  token_kind_i,
  input  logic [31:0] number_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        item_kind_o,
  output logic [31:0] sub_identifier_o,
  output logic        oid_end_o,
  output logic [1:0]  request_type_o,
  output logic [3:0]  error_code_o,
  output logic        last_o
);

  otp_pkg::ctrl_cmd_t cmd;
  otp_pkg::dp_sts_t   sts;

  otp_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .token_kind_i (token_kind_i),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  otp_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .number_value_i   (number_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .item_kind_o      (item_kind_o),
    .sub_identifier_o (sub_identifier_o),
    .oid_end_o        (oid_end_o),
    .request_type_o   (request_type_o),
    .error_code_o     (error_code_o),
    .last_o           (last_o)
  );

endmodule

/* design/otp_dp.sv */
// ----------------------------------------------------------------------------
// otp_dp
// Datapath: OID buffer memory with fill count, emission index with
// prefetching read, and the result output register.
// ----------------------------------------------------------------------------
module otp_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  otp_pkg::ctrl_cmd_t  cmd_i,
  output otp_pkg::dp_sts_t    sts_o,
  input  logic [31:0]         number_value_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                item_kind_o,
  output logic [31:0]         sub_identifier_o,
  output logic                oid_end_o,
  output logic [1:0]          request_type_o,
  output logic [3:0]          error_code_o,
  output logic                last_o
);

  logic [31:0]                mem [otp_pkg::MAX_OID_LEN];
  logic [otp_pkg::CNT_W-1:0]  count_q, count_d;
  logic [otp_pkg::CNT_W-1:0]  idx_q, idx_d;
  logic [otp_pkg::CNT_W-1:0]  idx_inc;
  logic [otp_pkg::IDX_W-1:0]  rd_addr;
  logic [31:0]                rd_q;
  logic                       out_valid_q, out_valid_d;
  logic                       kind_q;
  logic [31:0]                sub_q;
  logic                       end_q;
  logic [1:0]                 rq_q;
  logic [3:0]                 err_q;
  logic                       last_q;
  logic                       full;

  assign full    = (count_q == otp_pkg::CNT_W'(otp_pkg::MAX_OID_LEN));
  assign idx_inc = idx_q + 1'b1;

  // status back to the controller
  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.sub_final  = (idx_inc == count_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // fill count
  always_comb begin
    count_d = count_q;
    if (cmd_i.clr_count) begin
      count_d = '0;
    end else if (cmd_i.store_num && !full) begin
      count_d = count_q + 1'b1;
    end
  end

  // emission index; read address runs one entry ahead
  always_comb begin
    idx_d   = idx_q;
    rd_addr = idx_inc[otp_pkg::IDX_W-1:0];
    if (cmd_i.idx_clr) begin
      idx_d   = '0;
      rd_addr = '0;
    end else if (cmd_i.load_sub) begin
      idx_d = idx_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  // buffer memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_num && !full) begin
      mem[count_q[otp_pkg::IDX_W-1:0]] <= number_value_i;
    end
    if (cmd_i.idx_clr || cmd_i.load_sub) begin
      rd_q <= mem[rd_addr];
    end
  end

  // output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.load_sub || cmd_i.load_stat) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_sub) begin
      kind_q <= otp_pkg::KIND_SUB;
      sub_q  <= rd_q;
      end_q  <= sts_o.sub_final;
      rq_q   <= otp_pkg::RQ_GET;
      err_q  <= otp_pkg::ERR_OK;
      last_q <= sts_o.sub_final && cmd_i.sub_last;
    end else if (cmd_i.load_stat) begin
      kind_q <= otp_pkg::KIND_STATUS;
      sub_q  <= '0;
      end_q  <= 1'b0;
      rq_q   <= cmd_i.stat_rq;
      err_q  <= cmd_i.stat_err;
      last_q <= 1'b1;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign item_kind_o      = kind_q;
  assign sub_identifier_o = sub_q;
  assign oid_end_o        = end_q;
  assign request_type_o   = rq_q;
  assign error_code_o     = err_q;
  assign last_o           = last_q;

  // emission only from a non-empty buffer
  a_sub_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_sub |-> (count_q != '0))
    else $error("sub-identifier emitted from empty buffer");

  // fill count never exceeds capacity
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store_num |=> (count_q <= otp_pkg::CNT_W'(otp_pkg::MAX_OID_LEN)))
    else $error("buffer count overflow");

  // a waiting result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=>
      (out_valid_q && $stable(kind_q) && $stable(sub_q) && $stable(last_q)))
    else $error("waiting result changed");

endmodule

/* design/otp_ctrl.sv */
// ----------------------------------------------------------------------------
// otp_ctrl
// Controller: path parse state machine (token legality, request kind,
// recorded error) and the result sequencer that drains the OID buffer and
// issues the status result.
// ----------------------------------------------------------------------------
module otp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [3:0]          token_kind_i,
  input  otp_pkg::dp_sts_t    sts_i,
  output otp_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [8:0] {
    P_START   = 9'b000000001,
    P_INOID   = 9'b000000010,
    P_INDOT   = 9'b000000100,
    P_INLIST  = 9'b000001000,
    P_LISTOID = 9'b000010000,
    P_LISTDOT = 9'b000100000,
    P_OUTLIST = 9'b001000000,
    P_DONE    = 9'b010000000,
    P_ERROR   = 9'b100000000
  } parse_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EMIT = 3'b010,
    S_STAT = 3'b100
  } seq_e;

  parse_e         parse_q, parse_d;
  seq_e           seq_q, seq_d;
  otp_pkg::rq_e   rq_q, rq_d;
  otp_pkg::err_e  err_q, err_d;
  otp_pkg::err_e  stat_err_q, stat_err_d;
  logic           stat_pend_q, stat_pend_d;
  logic           accept;

  // token decode results
  logic           t_store;
  logic           t_emit;
  logic           t_stat;
  otp_pkg::err_e  t_err;
  otp_pkg::err_e  t_stat_err;

  assign in_ready_o = (seq_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // parse step for the offered token
  always_comb begin
    parse_d      = parse_q;
    rq_d         = rq_q;
    t_store      = 1'b0;
    t_emit       = 1'b0;
    t_stat       = 1'b0;
    t_err        = otp_pkg::ERR_OK;
    t_stat_err   = otp_pkg::ERR_OK;
    if (parse_q == P_ERROR) begin
      // ignore everything until end
      if (token_kind_i == otp_pkg::TK_END) begin
        t_stat     = 1'b1;
        t_stat_err = err_q;
        parse_d    = P_START;
      end
    end else begin
      case (token_kind_i)
        otp_pkg::TK_END: begin
          t_stat  = 1'b1;
          parse_d = P_START;
          if (parse_q == P_INOID) begin
            t_emit = 1'b1;
          end else if (!(parse_q inside {P_OUTLIST, P_DONE})) begin
            t_stat_err = otp_pkg::ERR_EOF;
          end
        end
        otp_pkg::TK_LPAREN: begin
          if (parse_q == P_START) parse_d = P_INLIST;
          else t_err = otp_pkg::ERR_LPAREN;
        end
        otp_pkg::TK_RPAREN: begin
          if (parse_q == P_LISTOID) begin
            t_emit  = 1'b1;
            parse_d = P_OUTLIST;
          end else begin
            t_err = otp_pkg::ERR_RPAREN;
          end
        end
        otp_pkg::TK_COMMA: begin
          if (parse_q == P_LISTOID) begin
            t_emit  = 1'b1;
            parse_d = P_INLIST;
          end else begin
            t_err = otp_pkg::ERR_COMMA;
          end
        end
        otp_pkg::TK_NUMBER: begin
          if (parse_q inside {P_START, P_INDOT}) begin
            t_store = 1'b1;
            parse_d = P_INOID;
          end else if (parse_q inside {P_INLIST, P_LISTDOT}) begin
            t_store = 1'b1;
            parse_d = P_LISTOID;
          end else begin
            t_err = otp_pkg::ERR_NUMBER;
          end
        end
        otp_pkg::TK_DOT: begin
          if (parse_q inside {P_INOID, P_OUTLIST}) parse_d = P_INDOT;
          else if (parse_q == P_LISTOID) parse_d = P_LISTDOT;
          else t_err = otp_pkg::ERR_DOT;
        end
        otp_pkg::TK_STAR: begin
          if (parse_q == P_INDOT) begin
            t_emit  = 1'b1;
            rq_d    = otp_pkg::RQ_WALK;
            parse_d = P_DONE;
          end else begin
            t_err = otp_pkg::ERR_STAR;
          end
        end
        otp_pkg::TK_PLUS: begin
          if (parse_q inside {P_INOID, P_OUTLIST}) begin
            t_emit  = (parse_q == P_INOID);
            rq_d    = otp_pkg::RQ_NEXT;
            parse_d = P_DONE;
          end else begin
            t_err = otp_pkg::ERR_PLUS;
          end
        end
        default: begin
          t_err = otp_pkg::ERR_TOKEN;
        end
      endcase
      if (t_err != otp_pkg::ERR_OK) begin
        parse_d = P_ERROR;
      end
    end
  end

  // result sequencer
  always_comb begin
    seq_d           = seq_q;
    err_d           = err_q;
    stat_err_d      = stat_err_q;
    stat_pend_d     = stat_pend_q;
    cmd_o.store_num = t_store && accept;
    cmd_o.clr_count = 1'b0;
    cmd_o.idx_clr   = 1'b0;
    cmd_o.load_sub  = 1'b0;
    cmd_o.load_stat = 1'b0;
    cmd_o.sub_last  = !stat_pend_q;
    cmd_o.stat_rq   = rq_q;
    cmd_o.stat_err  = stat_err_q;
    case (seq_q)
      S_IDLE: begin
        if (accept) begin
          if (t_err != otp_pkg::ERR_OK) begin
            err_d = t_err;
          end
          stat_pend_d = t_stat;
          stat_err_d  = t_stat_err;
          if (t_emit && !sts_i.count_zero) begin
            cmd_o.idx_clr = 1'b1;
            seq_d         = S_EMIT;
          end else if (t_stat) begin
            seq_d = S_STAT;
          end
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_sub = 1'b1;
          if (sts_i.sub_final) begin
            cmd_o.clr_count = 1'b1;
            seq_d           = stat_pend_q ? S_STAT : S_IDLE;
          end
        end
      end
      S_STAT: begin
        if (sts_i.out_free) begin
          cmd_o.load_stat = 1'b1;
          cmd_o.clr_count = 1'b1;
          seq_d           = S_IDLE;
        end
      end
      default: begin
        seq_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q     <= P_START;
      seq_q       <= S_IDLE;
      rq_q        <= otp_pkg::RQ_GET;
      err_q       <= otp_pkg::ERR_OK;
      stat_err_q  <= otp_pkg::ERR_OK;
      stat_pend_q <= 1'b0;
    end else begin
      seq_q       <= seq_d;
      err_q       <= err_d;
      stat_err_q  <= stat_err_d;
      stat_pend_q <= stat_pend_d;
      if (accept) begin
        parse_q <= parse_d;
      end
      // request kind survives until its status is out
      if (cmd_o.load_stat) begin
        rq_q <= otp_pkg::RQ_GET;
      end else if (accept) begin
        rq_q <= rq_d;
      end
    end
  end

  // results only go into a free output register
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_sub || cmd_o.load_stat) |-> sts_i.out_free)
    else $error("result loaded into busy output register");

  // a status result always restarts the parse
  a_stat_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_stat |=> (parse_q == P_START && rq_q == otp_pkg::RQ_GET))
    else $error("parser not restarted after status");

  // an error state always has a recorded error code of its own
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (parse_q == P_ERROR) |-> (err_q != otp_pkg::ERR_OK && err_q != otp_pkg::ERR_EOF))
    else $error("error state without recorded code");

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the OID path token parser. Token paths are pushed
// through the request channel, each accepted token is run through a local
// parse predictor, and every result leaving the block is compared field by
// field with the oldest predicted one. Directed paths come first, then
// random well-formed, broken and noise paths under varying idle and stall.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import otp_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned LONG_HOLD   = 150;

  // Parse states of the predictor
  typedef enum logic [3:0] {
    PS_START,
    PS_IN_OID,
    PS_IN_DOT,
    PS_IN_LIST,
    PS_IN_LIST_OID,
    PS_IN_LIST_DOT,
    PS_OUT_LIST,
    PS_DONE,
    PS_ERROR
  } pstate_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] sub;
    logic        oid_end;
    rq_e         rq;
    err_e        err;
    logic        last;
  } oid_result_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] value;
  } token_t;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [3:0]  token_kind_i   = TK_END;
  logic [31:0] number_value_i = '0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic        item_kind_o;
  logic [31:0] sub_identifier_o;
  logic        oid_end_o;
  logic [1:0]  request_type_o;
  logic [3:0]  error_code_o;
  logic        last_o;

  // Predictor state
  pstate_e     ps;
  err_e        fault_seen;
  rq_e         rq_now;
  logic [31:0] oid_buf [MAX_OID_LEN];
  int unsigned oid_len;
  oid_result_t step_q[$];
  oid_result_t parsed_items_q[$];

  token_t      path_q[$];
  int unsigned fail_count    = 0;
  int unsigned items_sent    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req      = 0;
  int unsigned quiet_cycles  = 0;

  oid_path_token_parser_top uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .token_kind_i     (token_kind_i),
    .number_value_i   (number_value_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .item_kind_o      (item_kind_o),
    .sub_identifier_o (sub_identifier_o),
    .oid_end_o        (oid_end_o),
    .request_type_o   (request_type_o),
    .error_code_o     (error_code_o),
    .last_o           (last_o)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------- predictor

  function automatic void restart_path();
    ps      = PS_START;
    oid_len = 0;
    rq_now  = RQ_GET;
  endfunction

  // Drain the buffered OID as sub-identifier results
  function automatic void flush_oid();
    oid_result_t r;
    int unsigned i;
    for (i = 0; i < oid_len; i++) begin
      r         = '0;
      r.kind    = KIND_SUB;
      r.sub     = oid_buf[i];
      r.oid_end = (i + 1 == oid_len);
      step_q.push_back(r);
    end
    oid_len = 0;
  endfunction

  function automatic void push_status(err_e code);
    oid_result_t r;
    r      = '0;
    r.kind = KIND_STATUS;
    r.rq   = rq_now;
    r.err  = code;
    step_q.push_back(r);
  endfunction

  function automatic void parse_token(logic [3:0] kind_raw, logic [31:0] value);
    tok_e        k;
    err_e        fault;
    oid_result_t r;
    k     = (kind_raw > TK_OTHER) ? TK_OTHER : tok_e'(kind_raw);
    fault = ERR_OK;
    step_q.delete();
    if (ps == PS_ERROR) begin
      // everything up to the end token is swallowed
      if (k == TK_END) begin
        push_status(fault_seen);
        restart_path();
      end
    end else begin
      case (k)
        TK_END: begin
          if (ps == PS_IN_OID) flush_oid();
          push_status((ps inside {PS_IN_OID, PS_OUT_LIST, PS_DONE}) ? ERR_OK : ERR_EOF);
          restart_path();
        end
        TK_LPAREN: begin
          if (ps == PS_START) ps = PS_IN_LIST;
          else fault = ERR_LPAREN;
        end
        TK_RPAREN: begin
          if (ps == PS_IN_LIST_OID) begin
            flush_oid();
            ps = PS_OUT_LIST;
          end else fault = ERR_RPAREN;
        end
        TK_COMMA: begin
          if (ps == PS_IN_LIST_OID) begin
            flush_oid();
            ps = PS_IN_LIST;
          end else fault = ERR_COMMA;
        end
        TK_NUMBER: begin
          if (ps inside {PS_START, PS_IN_LIST, PS_IN_DOT, PS_IN_LIST_DOT}) begin
            // a full buffer drops the value but still takes the token
            if (oid_len < MAX_OID_LEN) begin
              oid_buf[oid_len] = value;
              oid_len++;
            end
            ps = (ps inside {PS_START, PS_IN_DOT}) ? PS_IN_OID : PS_IN_LIST_OID;
          end else fault = ERR_NUMBER;
        end
        TK_DOT: begin
          if (ps inside {PS_IN_OID, PS_OUT_LIST}) ps = PS_IN_DOT;
          else if (ps == PS_IN_LIST_OID) ps = PS_IN_LIST_DOT;
          else fault = ERR_DOT;
        end
        TK_STAR: begin
          if (ps == PS_IN_DOT) begin
            flush_oid();
            rq_now = RQ_WALK;
            ps     = PS_DONE;
          end else fault = ERR_STAR;
        end
        TK_PLUS: begin
          if (ps inside {PS_IN_OID, PS_OUT_LIST}) begin
            flush_oid();
            rq_now = RQ_NEXT;
            ps     = PS_DONE;
          end else fault = ERR_PLUS;
        end
        default: fault = ERR_TOKEN;
      endcase
      if (fault != ERR_OK) begin
        ps         = PS_ERROR;
        fault_seen = fault;
      end
    end
    // flag the final result of this request
    if (step_q.size() > 0) begin
      r      = step_q.pop_back();
      r.last = 1'b1;
      step_q.push_back(r);
    end
    foreach (step_q[i]) parsed_items_q.push_back(step_q[i]);
  endfunction

  // ------------------------------------------------------------------ checker

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_result
    oid_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (parsed_items_q.size() == 0) begin
        fail_count++;
        $display("%0t ns: unexpected result, expected none, actual kind %0d sub %0h err %0d",
                 $time, item_kind_o, sub_identifier_o, error_code_o);
      end else begin
        want = parsed_items_q.pop_front();
        check_field("item_kind", 32'(want.kind), 32'(item_kind_o));
        check_field("sub_identifier", want.sub, sub_identifier_o);
        check_field("oid_end", 32'(want.oid_end), 32'(oid_end_o));
        check_field("request_type", 32'(want.rq), 32'(request_type_o));
        check_field("error_code", 32'(want.err), 32'(error_code_o));
        check_field("last", 32'(want.last), 32'(last_o));
      end
    end
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: random stall, or a long hold-off when requested
  initial begin : receiver
    int unsigned stall_n;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        stall_n  = hold_req;
        hold_req = 0;
        out_ready_i <= 1'b0;
        repeat (stall_n - 1) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic send_token(logic [3:0] kind, logic [31:0] value);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99, 0) < send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    token_kind_i   <= kind;
    number_value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    parse_token(kind, value);
    items_sent++;
  endtask

  task automatic send_path();
    foreach (path_q[i]) send_token(path_q[i].kind, path_q[i].value);
    path_q.delete();
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    while (parsed_items_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic void add(logic [3:0] kind, logic [31:0] value = '0);
    token_t t;
    t.kind  = kind;
    t.value = value;
    path_q.push_back(t);
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_oid(int unsigned len);
    int unsigned i;
    for (i = 0; i < len; i++) begin
      if (i > 0) add(TK_DOT, rand_value());
      add(TK_NUMBER, rand_value());
    end
  endfunction

  function automatic int unsigned rand_oid_len();
    return ($urandom_range(39, 0) == 0) ? $urandom_range(MAX_OID_LEN + 2, MAX_OID_LEN - 2)
                                        : $urandom_range(4, 1);
  endfunction

  // Build one path: mostly well formed, some with a corrupted token, some noise
  function automatic void gen_path();
    int unsigned pick;
    int unsigned n;
    int unsigned pos;
    token_t      t;
    pick = $urandom_range(99, 0);
    if (pick < 15) begin
      n = $urandom_range(6, 1);
      repeat (n) add(4'($urandom_range(15, 0)), rand_value());
      add(TK_END, rand_value());
    end else begin
      if ($urandom_range(1, 0) == 0) begin
        add_oid(rand_oid_len());
      end else begin
        add(TK_LPAREN, rand_value());
        n = $urandom_range(3, 1);
        repeat (n) begin
          add_oid(rand_oid_len());
          if (--n > 0) add(TK_COMMA, rand_value());
        end
        add(TK_RPAREN, rand_value());
      end
      case ($urandom_range(2, 0))
        0: ;
        1: add(TK_PLUS, rand_value());
        default: begin
          add(TK_DOT, rand_value());
          add(TK_STAR, rand_value());
        end
      endcase
      add(TK_END, rand_value());
      if (pick < 35) begin
        pos         = $urandom_range(path_q.size() - 2, 0);
        t.kind      = 4'($urandom_range(15, 0));
        t.value     = rand_value();
        path_q[pos] = t;
      end
    end
  endfunction

  // ------------------------------------------------------------------ tests

  // Plain get path with the smallest and largest sub-identifier
  task automatic test_get_extremes();
    add(TK_NUMBER, '0);
    add(TK_DOT);
    add(TK_NUMBER, '1);
    add(TK_DOT);
    add(TK_NUMBER, 32'd7);
    add(TK_END);
    send_path();
  endtask

  // List of two OIDs closed by plus: next request
  task automatic test_list_next();
    add(TK_LPAREN);
    add(TK_NUMBER, 32'd1);
    add(TK_DOT);
    add(TK_NUMBER, 32'h8000_0000);
    add(TK_COMMA);
    add(TK_NUMBER, 32'd3);
    add(TK_RPAREN);
    add(TK_PLUS);
    add(TK_END);
    send_path();
  endtask

  // List, dot, asterisk: walk request with an empty OID at the asterisk
  task automatic test_empty_oid_walk();
    add(TK_LPAREN);
    add(TK_NUMBER, 32'd5);
    add(TK_RPAREN);
    add(TK_DOT);
    add(TK_STAR);
    add(TK_END);
    send_path();
  endtask

  // End token with nothing parsed
  task automatic test_premature_end();
    add(TK_END);
    send_path();
  endtask

  // Token code above the legal range, then a swallowed number
  task automatic test_illegal_token();
    add(4'hF, '1);
    add(TK_NUMBER, 32'd9);
    add(TK_END);
    send_path();
  endtask

  // More numbers than the buffer holds: the excess is dropped
  task automatic test_buffer_full();
    add_oid(MAX_OID_LEN + 1);
    add(TK_END);
    send_path();
  endtask

  // Result side held off while tokens keep coming, so the input stalls
  task automatic test_backpressure();
    hold_req = LONG_HOLD;
    add(TK_LPAREN);
    add_oid(3);
    add(TK_COMMA);
    add_oid(2);
    add(TK_RPAREN);
    add(TK_END);
    send_path();
  endtask

  // Sender waits for every result before the next path
  task automatic test_drain_pause();
    add_oid(4);
    add(TK_PLUS);
    add(TK_END);
    send_path();
    pause_until_drained();
    add_oid(2);
    add(TK_DOT);
    add(TK_STAR);
    add(TK_END);
    send_path();
  endtask

  task automatic test_random(int unsigned idle_pct, int unsigned stall_pct,
                             int unsigned count);
    int unsigned stop_at;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    stop_at        = items_sent + count;
    while (items_sent < stop_at) begin
      gen_path();
      send_path();
    end
  endtask

  initial begin
    restart_path();
    fault_seen = ERR_OK;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_get_extremes();
    test_list_next();
    test_empty_oid_walk();
    test_premature_end();
    test_illegal_token();
    test_buffer_full();
    test_backpressure();
    test_drain_pause();
    test_random(0, 0, 20);
    test_random(69, 0, 20);
    test_random(0, 69, 20);
    test_random(31, 31, 20);
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // let the last results drain, then allow a few spare cycles
    pause_until_drained();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
design/otp_pkg.sv
design/otp_dp.sv
design/otp_ctrl.sv
design/oid_path_token_parser_top.sv
verif/tb_top.sv
